// File: rtl/tlr_pkg.sv
// package: frame geometry, coordinate widths and transaction types for the thick line rasterizer
package tlr_pkg;

    // frame geometry
    localparam int WORDS_PER_ROW = 128;
    localparam int FRAME_ROWS    = 192;
    localparam int FRAME_COLS    = 2 * WORDS_PER_ROW;
    localparam int STORE_WORDS   = WORDS_PER_ROW * FRAME_ROWS;
    localparam int ADDR_W        = $clog2(STORE_WORDS);

    // signed coordinate width: brush reaches 16 pixels past a line point
    localparam int CW = 12;

    // request type codes
    localparam logic REQ_DRAW = 1'b0;
    localparam logic REQ_READ = 1'b1;

    typedef struct packed {
        logic       req_type;
        logic [7:0] x_start;
        logic [7:0] y_start;
        logic [7:0] x_end;
        logic [7:0] y_end;
        logic [4:0] brush_width;
        logic [4:0] brush_height;
        logic [7:0] color_index;
    } t_req;

    typedef struct packed {
        logic [7:0] pixel_value;
        logic       clipped;
    } t_rsp;

    // one pixel access to the frame store
    typedef struct packed {
        logic              valid;
        logic              wr;
        logic              hi;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        color;
    } t_mem_req;

endpackage

// File: rtl/tlr_if.sv
// interfaces: request and response channels with valid/ready handshake

interface tlr_req_if;
    logic          valid;
    logic          ready;
    tlr_pkg::t_req payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface tlr_rsp_if;
    logic          valid;
    logic          ready;
    tlr_pkg::t_rsp payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/thick_line_rasterizer_8bpp.sv
// top level: request sequencer walking a Bresenham line and stamping a rectangular brush
//
//  channel  dir  handshake      payload
//  i_in     in   valid/ready    req_type, x/y start, x/y end, brush size, color_index
//  o_out    out  valid/ready    pixel_value, clipped
//
//  after reset the frame store is cleared one word a cycle, all 24576 words, ready low
//  a read goes through INIT, RDWAIT and DONE; RDWAIT is skipped when the row is off the frame
//  a draw stamps the brush in STAMP, then moves to the next line point in STEP, one brush
//  pixel a cycle through the frame store's read-modify-write port
//  one request at a time; the output register lets the next request in while a result waits
module thick_line_rasterizer_8bpp (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tlr_req_if.sink    i_in,
    tlr_rsp_if.source  o_out
);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_INIT   = 3'd2;
    localparam logic [2:0] S_STAMP  = 3'd3;
    localparam logic [2:0] S_STEP   = 3'd4;
    localparam logic [2:0] S_RDWAIT = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    localparam int CW = tlr_pkg::CW;

    logic [2:0] r_state;
    logic [2:0] n_state;

    tlr_pkg::t_req r_req;
    logic signed [CW-1:0] r_cx, r_cy;
    logic signed [CW-1:0] r_px, r_py;
    logic signed [CW-1:0] r_px0, r_px_last, r_py_last;
    logic [9:0]           r_dx2, r_dy2;
    logic                 r_sx_neg, r_sy_neg, r_xmaj;
    logic signed [CW-1:0] r_err;
    logic                 r_clip;
    logic [7:0]           r_pix;
    logic                 r_out_valid;
    tlr_pkg::t_rsp        r_out;

    tlr_pkg::t_mem_req mem_req;
    logic              frame_busy;
    logic [7:0]        frame_pixel;

    logic                 px_in_frame;
    logic                 brush_empty;
    logic [CW-1:0]        w_lo, w_hi, h_lo, h_hi;
    logic signed [CW-1:0] x_end_s, y_end_s;
    logic signed [9:0]    dxs, dys;
    logic [8:0]           adx, ady;
    logic [9:0]           i_dx2, i_dy2;
    logic                 i_xmaj;
    logic signed [CW-1:0] i_err;
    logic                 line_done;
    logic signed [CW-1:0] n_cx, n_cy, n_err;
    logic signed [CW-1:0] e1;

    // frame store
    tlr_frame u_frame (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mem_req),
        .o_busy  (frame_busy),
        .o_pixel (frame_pixel)
    );

    // current pixel clip test and word address
    assign px_in_frame = !r_px[CW-1] && (r_px < $signed(CW'(tlr_pkg::FRAME_COLS)))
                      && !r_py[CW-1] && (r_py < $signed(CW'(tlr_pkg::FRAME_ROWS)));

    always_comb begin
        mem_req.addr  = tlr_pkg::ADDR_W'(r_py[7:0]) * tlr_pkg::ADDR_W'(tlr_pkg::WORDS_PER_ROW)
                      + tlr_pkg::ADDR_W'(r_px[CW-2:1]);
        mem_req.hi    = r_px[0];
        mem_req.color = r_req.color_index;
        mem_req.wr    = (r_state == S_STAMP);
        mem_req.valid = px_in_frame && ((r_state == S_STAMP)
                     || (r_state == S_INIT && r_req.req_type == tlr_pkg::REQ_READ));
    end

    // brush extents: ceil(w/2) before the point, floor(w/2) from the point on
    assign w_lo = CW'((6'(r_req.brush_width) + 6'd1) >> 1);
    assign w_hi = CW'(r_req.brush_width >> 1);
    assign h_lo = CW'((6'(r_req.brush_height) + 6'd1) >> 1);
    assign h_hi = CW'(r_req.brush_height >> 1);
    assign brush_empty = (r_req.brush_width == 5'd0) || (r_req.brush_height == 5'd0);

    // line setup from the request
    assign x_end_s = $signed(CW'(r_req.x_end));
    assign y_end_s = $signed(CW'(r_req.y_end));
    assign dxs     = $signed({2'b00, r_req.x_end}) - $signed({2'b00, r_req.x_start});
    assign dys     = $signed({2'b00, r_req.y_end}) - $signed({2'b00, r_req.y_start});
    assign adx     = dxs[9] ? 9'(-dxs) : dxs[8:0];
    assign ady     = dys[9] ? 9'(-dys) : dys[8:0];
    assign i_dx2   = {adx, 1'b0};
    assign i_dy2   = {ady, 1'b0};
    assign i_xmaj  = i_dx2 > i_dy2;
    assign i_err   = i_xmaj ? ($signed(CW'(i_dy2)) - $signed(CW'(adx)))
                            : ($signed(CW'(i_dx2)) - $signed(CW'(ady)));

    // one Bresenham step, or the start point during setup
    always_comb begin
        n_cx  = r_cx;
        n_cy  = r_cy;
        n_err = r_err;
        e1    = r_err;
        line_done = r_xmaj ? (r_cx == x_end_s) : (r_cy == y_end_s);
        if (r_state == S_INIT) begin
            n_cx  = $signed(CW'(r_req.x_start));
            n_cy  = $signed(CW'(r_req.y_start));
            n_err = i_err;
        end else if (r_xmaj) begin
            if (!r_err[CW-1]) begin
                n_cy = r_sy_neg ? r_cy - 1'b1 : r_cy + 1'b1;
                e1   = r_err - $signed(CW'(r_dx2));
            end
            n_cx  = r_sx_neg ? r_cx - 1'b1 : r_cx + 1'b1;
            n_err = e1 + $signed(CW'(r_dy2));
        end else begin
            if (!r_err[CW-1]) begin
                n_cx = r_sx_neg ? r_cx - 1'b1 : r_cx + 1'b1;
                e1   = r_err - $signed(CW'(r_dy2));
            end
            n_cy  = r_sy_neg ? r_cy - 1'b1 : r_cy + 1'b1;
            n_err = e1 + $signed(CW'(r_dx2));
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:  if (!frame_busy) n_state = S_IDLE;
            S_IDLE:   if (i_in.valid) n_state = S_INIT;
            S_INIT: begin
                if (r_req.req_type == tlr_pkg::REQ_READ) begin
                    n_state = px_in_frame ? S_RDWAIT : S_DONE;
                end else begin
                    n_state = brush_empty ? S_DONE : S_STAMP;
                end
            end
            S_STAMP:  if (r_px == r_px_last && r_py == r_py_last) n_state = S_STEP;
            S_STEP:   n_state = line_done ? S_DONE : S_STAMP;
            S_RDWAIT: n_state = S_DONE;
            S_DONE:   if (!r_out_valid || o_out.ready) n_state = S_IDLE;
            default:  n_state = S_CLEAR;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == S_DONE && (!r_out_valid || o_out.ready)) begin
                r_out_valid <= 1'b1;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_req  <= i_in.payload;
                r_px   <= $signed(CW'(i_in.payload.x_start));
                r_py   <= $signed(CW'(i_in.payload.y_start));
                r_clip <= 1'b0;
                r_pix  <= 8'h00;
            end
            S_INIT: begin
                r_dx2    <= i_dx2;
                r_dy2    <= i_dy2;
                r_sx_neg <= dxs[9];
                r_sy_neg <= dys[9];
                r_xmaj   <= i_xmaj;
                if (r_req.req_type == tlr_pkg::REQ_READ) begin
                    r_clip <= !px_in_frame;
                end
            end
            S_STAMP: begin
                if (!px_in_frame) begin
                    r_clip <= 1'b1;
                end
                if (r_px == r_px_last) begin
                    r_px <= r_px0;
                    r_py <= r_py + 1'b1;
                end else begin
                    r_px <= r_px + 1'b1;
                end
            end
            S_RDWAIT: begin
                r_pix <= frame_pixel;
            end
            S_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    r_out.pixel_value <= r_pix;
                    r_out.clipped     <= r_clip;
                end
            end
            default: begin
            end
        endcase

        // brush setup around the start point or the next line point
        if ((r_state == S_INIT && r_req.req_type == tlr_pkg::REQ_DRAW)
                || (r_state == S_STEP && !line_done)) begin
            r_cx      <= n_cx;
            r_cy      <= n_cy;
            r_err     <= n_err;
            r_px      <= n_cx - $signed(w_lo);
            r_px0     <= n_cx - $signed(w_lo);
            r_px_last <= n_cx + $signed(w_hi) - 1'b1;
            r_py      <= n_cy - $signed(h_lo);
            r_py_last <= n_cy + $signed(h_hi) - 1'b1;
        end
    end

    assign i_in.ready    = (r_state == S_IDLE);
    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

endmodule

// File: rtl/tlr_frame.sv
// frame store: word memory with pixel read-modify-write, forwarding and clear pass after reset
module tlr_frame (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tlr_pkg::t_mem_req i_req,
    output logic              o_busy,
    output logic [7:0]        o_pixel
);

    logic [15:0] r_mem [tlr_pkg::STORE_WORDS];

    logic                      r_clearing;
    logic [tlr_pkg::ADDR_W-1:0] r_clr_addr;
    logic [15:0]               r_rd_word;
    tlr_pkg::t_mem_req         r_stage;
    logic                      r_fwd;
    logic [15:0]               r_fwd_word;

    logic [15:0]                cur_word;
    logic [15:0]                merged;
    logic                       wen;
    logic [tlr_pkg::ADDR_W-1:0] waddr;
    logic [15:0]                wdata;

    // word seen by the second stage: forwarded if the previous write hit the same word
    assign cur_word = r_fwd ? r_fwd_word : r_rd_word;
    assign merged   = r_stage.hi ? {r_stage.color, cur_word[7:0]}
                                 : {cur_word[15:8], r_stage.color};
    assign o_pixel  = r_stage.hi ? cur_word[15:8] : cur_word[7:0];
    assign o_busy   = r_clearing;

    // single write port shared by clear pass and pixel writes
    assign wen   = r_clearing || (r_stage.valid && r_stage.wr);
    assign waddr = r_clearing ? r_clr_addr : r_stage.addr;
    assign wdata = r_clearing ? 16'h0000 : merged;

    // memory array
    always_ff @(posedge i_clk) begin
        if (wen) begin
            r_mem[waddr] <= wdata;
        end
        if (i_req.valid) begin
            r_rd_word <= r_mem[i_req.addr];
        end
    end

    // forwarding capture
    always_ff @(posedge i_clk) begin
        r_fwd_word <= wdata;
        r_stage.wr    <= i_req.wr;
        r_stage.hi    <= i_req.hi;
        r_stage.addr  <= i_req.addr;
        r_stage.color <= i_req.color;
    end

    // control: clear sweep, stage valid, forward flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing    <= 1'b1;
            r_clr_addr    <= '0;
            r_stage.valid <= 1'b0;
            r_fwd         <= 1'b0;
        end else begin
            r_stage.valid <= i_req.valid;
            r_fwd         <= wen && i_req.valid && (waddr == i_req.addr);
            if (r_clearing) begin
                if (r_clr_addr == tlr_pkg::ADDR_W'(tlr_pkg::STORE_WORDS - 1)) begin
                    r_clearing <= 1'b0;
                end
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

endmodule

// File: rtl/tlr_checker.sv
// checker: port-level assertions for the thick line rasterizer, bound to the top level
module tlr_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          i_in_ready,
    input logic          i_out_valid,
    input logic          i_out_ready,
    input tlr_pkg::t_rsp i_out_data
);

    // reset starts the clear sweep: nothing accepted, nothing offered
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_in_ready && !i_out_valid)
        else $error("ready or valid high right after reset");

    // one request in flight: ready drops after each input transaction
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second request taken while one is in flight");

    // a nonzero pixel only comes from an in-frame read
    a_pixel_not_clipped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_data.pixel_value != 8'h00) |-> !i_out_data.clipped)
        else $error("clipped result carries a pixel value");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("result changed or dropped while stalled");

endmodule

bind thick_line_rasterizer_8bpp tlr_checker u_tlr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.payload)
);

// File: dv/tb_thick_line_rasterizer_8bpp.sv
// testbench: thick line rasterizer checked against a shadow frame store, random idling phases
`timescale 1ns / 1ps

module tb_thick_line_rasterizer_8bpp;

    logic i_clk;
    logic i_rst_n;

    tlr_req_if req_if ();
    tlr_rsp_if rsp_if ();

    thick_line_rasterizer_8bpp u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if),
        .o_out   (rsp_if)
    );

    // shadow copy of the frame store, updated when a transaction is accepted
    logic [15:0]   frame_shadow [tlr_pkg::STORE_WORDS];
    tlr_pkg::t_rsp expected_rsp_q [$];
    int            recent_centers [$];

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int mismatch_count = 0;
    int results_seen   = 0;
    int draws_sent     = 0;
    int reads_sent     = 0;
    int clipped_seen   = 0;

    // clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // ---------------------------------------------------------------- predictor

    // writes one byte of the shadow store; returns 1 when the pixel is off the frame
    function automatic bit shadow_put(int x, int y, logic [7:0] color);
        int idx;
        if (x < 0 || x >= tlr_pkg::FRAME_COLS || y < 0 || y >= tlr_pkg::FRAME_ROWS)
            return 1'b1;
        idx = y * tlr_pkg::WORDS_PER_ROW + x / 2;
        if (x % 2 == 0)
            frame_shadow[idx][7:0] = color;
        else
            frame_shadow[idx][15:8] = color;
        return 1'b0;
    endfunction

    // brush spans x-ceil(w/2) .. x+floor(w/2)-1, same in y
    function automatic bit shadow_stamp(int cx, int cy, int bw, int bh, logic [7:0] color);
        int x0;
        int x1;
        int y0;
        int y1;
        bit clip;
        x0   = cx - (bw + 1) / 2;
        x1   = cx + bw / 2;
        y0   = cy - (bh + 1) / 2;
        y1   = cy + bh / 2;
        clip = 1'b0;
        for (int row = y0; row < y1; row++)
            for (int col = x0; col < x1; col++)
                if (shadow_put(col, row, color))
                    clip = 1'b1;
        return clip;
    endfunction

    // Bresenham walk with doubled deltas, stamping at every point including the start
    function automatic bit shadow_line(int xa, int ya, int xb, int yb, int bw, int bh,
                                       logic [7:0] color);
        int dx;
        int dy;
        int sx;
        int sy;
        int err;
        bit clip;
        dx = xb - xa;
        dy = yb - ya;
        sx = 1;
        sy = 1;
        if (dx < 0) begin
            dx = -dx;
            sx = -1;
        end
        if (dy < 0) begin
            dy = -dy;
            sy = -1;
        end
        dx   = dx * 2;
        dy   = dy * 2;
        clip = shadow_stamp(xa, ya, bw, bh, color);
        if (dx > dy) begin
            err = dy - dx / 2;
            while (xa != xb) begin
                if (err >= 0) begin
                    ya  += sy;
                    err -= dx;
                end
                xa  += sx;
                err += dy;
                if (shadow_stamp(xa, ya, bw, bh, color))
                    clip = 1'b1;
            end
        end else begin
            err = dx - dy / 2;
            while (ya != yb) begin
                if (err >= 0) begin
                    xa  += sx;
                    err -= dy;
                end
                ya  += sy;
                err += dx;
                if (shadow_stamp(xa, ya, bw, bh, color))
                    clip = 1'b1;
            end
        end
        return clip;
    endfunction

    // expected result of one request, applying draws to the shadow store
    function automatic tlr_pkg::t_rsp predict_response(tlr_pkg::t_req r);
        tlr_pkg::t_rsp rsp;
        logic [15:0]   word;
        int            x;
        int            y;
        rsp = '0;
        x   = int'(r.x_start);
        y   = int'(r.y_start);
        if (r.req_type == tlr_pkg::REQ_READ) begin
            if (y < tlr_pkg::FRAME_ROWS) begin
                word            = frame_shadow[y * tlr_pkg::WORDS_PER_ROW + x / 2];
                rsp.pixel_value = (x % 2 == 1) ? word[15:8] : word[7:0];
            end else begin
                rsp.clipped = 1'b1;
            end
        end else begin
            rsp.clipped = shadow_line(x, y, int'(r.x_end), int'(r.y_end),
                                      int'(r.brush_width), int'(r.brush_height),
                                      r.color_index);
        end
        return rsp;
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic report_mismatch(string what, int got, int want);
        if (mismatch_count < 100)
            $display("ERROR at %0t result %0d: %s got %0h expected %0h",
                     $realtime, results_seen, what, got, want);
        mismatch_count++;
    endtask

    // compare each response transaction with the oldest expectation
    always @(posedge i_clk) begin : rsp_check
        tlr_pkg::t_rsp want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (expected_rsp_q.size() == 0) begin
                report_mismatch("unexpected response", rsp_if.payload, 0);
            end else begin
                want = expected_rsp_q.pop_front();
                if (rsp_if.payload.pixel_value !== want.pixel_value)
                    report_mismatch("pixel_value", rsp_if.payload.pixel_value,
                                    want.pixel_value);
                if (rsp_if.payload.clipped !== want.clipped)
                    report_mismatch("clipped", rsp_if.payload.clipped, want.clipped);
                if (want.clipped)
                    clipped_seen++;
            end
            results_seen++;
        end
    end

    // receiver back-pressure
    always @(negedge i_clk) begin
        rsp_if.ready <= (sink_stall_pct == 0) || ($urandom_range(99) >= sink_stall_pct);
    end

    // ---------------------------------------------------------------- driving

    // one request transaction; starts and returns at a falling edge with valid still high
    task automatic send_req(tlr_pkg::t_req r);
        while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_if.valid   <= 1'b1;
        req_if.payload <= r;
        do
            @(posedge i_clk);
        while (!req_if.ready);
        expected_rsp_q.push_back(predict_response(r));
        if (r.req_type == tlr_pkg::REQ_READ)
            reads_sent++;
        else
            draws_sent++;
        @(negedge i_clk);
    endtask

    task automatic draw(int xs, int ys, int xe, int ye, int bw, int bh, logic [7:0] color);
        tlr_pkg::t_req r;
        r              = '0;
        r.req_type     = tlr_pkg::REQ_DRAW;
        r.x_start      = xs[7:0];
        r.y_start      = ys[7:0];
        r.x_end        = xe[7:0];
        r.y_end        = ye[7:0];
        r.brush_width  = bw[4:0];
        r.brush_height = bh[4:0];
        r.color_index  = color;
        send_req(r);
    endtask

    task automatic read_px(int x, int y);
        tlr_pkg::t_req r;
        r          = '0;
        r.req_type = tlr_pkg::REQ_READ;
        r.x_start  = x[7:0];
        r.y_start  = y[7:0];
        send_req(r);
    endtask

    // drop valid, then wait for every expected response plus some slack
    task automatic drain();
        req_if.valid <= 1'b0;
        while (expected_rsp_q.size() != 0)
            @(negedge i_clk);
        repeat (64) @(negedge i_clk);
    endtask

    function automatic logic [7:0] clamp8(int v);
        if (v < 0)
            return 8'd0;
        if (v > 255)
            return 8'd255;
        return v[7:0];
    endfunction

    // mix of short draws, a few big brushes and long thin lines, reads mostly near drawn areas
    task automatic run_random_traffic(int n_items);
        tlr_pkg::t_req r;
        logic [63:0]   noise;
        int            pick;
        int            kind;
        int            center;
        for (int k = 0; k < n_items; k++) begin
            noise = {$urandom, $urandom};
            r     = noise[$bits(tlr_pkg::t_req)-1:0];
            pick  = $urandom_range(99);
            if (pick < 45) begin
                r.req_type = tlr_pkg::REQ_DRAW;
                kind       = $urandom_range(99);
                r.y_start  = (kind % 5 == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(199));
                if (kind < 88) begin
                    r.x_end        = clamp8(int'(r.x_start) + int'($urandom_range(12)) - 6);
                    r.y_end        = clamp8(int'(r.y_start) + int'($urandom_range(12)) - 6);
                    r.brush_width  = 5'($urandom_range(5));
                    r.brush_height = 5'($urandom_range(5));
                end else if (kind < 94) begin
                    r.x_end = clamp8(int'(r.x_start) + int'($urandom_range(4)) - 2);
                    r.y_end = clamp8(int'(r.y_start) + int'($urandom_range(4)) - 2);
                end else begin
                    r.brush_width  = 5'($urandom_range(2));
                    r.brush_height = 5'($urandom_range(2));
                end
                recent_centers.push_back({r.x_start, r.y_start});
                if (recent_centers.size() > 16)
                    void'(recent_centers.pop_front());
            end else begin
                r.req_type = tlr_pkg::REQ_READ;
                if (pick < 90 && recent_centers.size() != 0) begin
                    center    = recent_centers[$urandom_range(recent_centers.size() - 1)];
                    r.x_start = clamp8(center / 256 + int'($urandom_range(12)) - 6);
                    r.y_start = clamp8(center % 256 + int'($urandom_range(12)) - 6);
                end
            end
            send_req(r);
        end
    endtask

    // ---------------------------------------------------------------- tests

    // frame store comes up cleared; rows past the frame report clipped
    task automatic test_after_reset_reads();
        read_px(0, 0);
        read_px(255, 191);
        read_px(0, 255);
        drain();
    endtask

    task automatic test_directed_draws();
        // degenerate line with 1x1 brush lands up-left of the point
        draw(10, 10, 10, 10, 1, 1, 8'hFF);
        read_px(9, 9);
        read_px(10, 9);
        // empty brushes stamp nothing and never clip
        draw(0, 0, 5, 5, 0, 5, 8'h11);
        draw(255, 191, 250, 180, 31, 0, 8'h22);
        // largest brush at both frame corners
        draw(0, 0, 0, 0, 31, 31, 8'hAA);
        read_px(0, 0);
        read_px(14, 14);
        draw(255, 191, 255, 191, 31, 31, 8'h55);
        read_px(255, 191);
        read_px(239, 175);
        // full-width, full-height and diagonal lines
        draw(0, 100, 255, 100, 2, 1, 8'h0F);
        draw(200, 0, 200, 255, 1, 2, 8'h00);
        draw(255, 191, 0, 0, 1, 1, 8'hF0);
        draw(3, 0, 0, 191, 3, 3, 8'h3C);
        // both bytes of one word written separately, the other byte kept
        draw(21, 50, 21, 50, 1, 1, 8'h81);
        draw(22, 50, 22, 50, 1, 1, 8'h7E);
        read_px(20, 49);
        read_px(21, 49);
        // mid-size brush on a steep-ish segment, then a line leaving the frame
        draw(128, 60, 140, 52, 16, 17, 8'hC3);
        read_px(130, 55);
        read_px(201, 100);
        draw(250, 190, 255, 255, 3, 3, 8'h99);
        read_px(254, 191);
        drain();
    endtask

    task automatic test_traffic_no_idle();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        run_random_traffic(270);
        drain();
    endtask

    task automatic test_traffic_sender_idle();
        src_idle_pct   = 57;
        sink_stall_pct = 0;
        run_random_traffic(270);
        drain();
    endtask

    task automatic test_traffic_receiver_stall();
        src_idle_pct   = 0;
        sink_stall_pct = 57;
        run_random_traffic(270);
        drain();
    endtask

    task automatic test_traffic_both_idle();
        src_idle_pct   = 21;
        sink_stall_pct = 21;
        run_random_traffic(270);
        drain();
    endtask

    // ---------------------------------------------------------------- main sequence

    initial begin
        foreach (frame_shadow[i])
            frame_shadow[i] = '0;
        i_rst_n        = 1'b0;
        req_if.valid   = 1'b0;
        req_if.payload = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_after_reset_reads();
        test_directed_draws();
        test_traffic_no_idle();
        test_traffic_sender_idle();
        test_traffic_receiver_stall();
        test_traffic_both_idle();

        $display("covered %0d draws and %0d pixel reads over four idling phases",
                 draws_sent, reads_sent);
        $display("%0d responses checked, %0d of them clipped", results_seen, clipped_seen);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // run limit, well beyond the clearing pass plus the slowest legal traffic
    initial begin
        #(20_000_000);
        $display("timeout with %0d responses outstanding", expected_rsp_q.size());
        $display("Mismatches found");
        $finish;
    end

endmodule
